FILE: src/osn_pkg.sv
// ----------------------------------------------------------------------------
// osn_pkg
// Shared constants, types and helper functions for the octave simplex noise
// block.
// ----------------------------------------------------------------------------
package osn_pkg;

    localparam int TABLE_SIZE  = 256;
    localparam int TABLE_AW    = $clog2(TABLE_SIZE);
    localparam int VAL_W       = 8;
    localparam int MAX_OCTAVES = 8;
    localparam int OCT_W       = 4;
    localparam int FRAC_BITS   = 16;
    localparam int SCALE_FRAC  = 16;
    localparam int DATA_W      = 32;
    localparam int CFG_IDX_W   = 2;

    localparam int WIDE_W = 64;         // coordinate datapath
    localparam int MUL_W  = 33;         // shared multiplier operand
    localparam int PROD_W = 2 * MUL_W;
    localparam int Q_W    = 27;         // Q24 corner offsets
    localparam int R_W    = 31;         // falloff term before the sign test
    localparam int DOT_W  = 28;
    localparam int NSUM_W = 28;
    localparam int M_W    = 41;         // mapped octave value
    localparam int ACC_W  = 50;         // weighted octave sum
    localparam int DEN_W  = 8;
    localparam int SH_W   = 5;

    localparam logic [DATA_W-1:0] F2_Q32 = 32'd1572067139;
    localparam logic [DATA_W-1:0] G2_Q32 = 32'd907633386;

    localparam logic signed [Q_W-1:0] G2_Q24 = 27'sd3545443;
    localparam logic signed [Q_W-1:0] ONE24  = 27'sd16777216;
    localparam logic signed [R_W-1:0] HALF24 = 31'sd8388608;
    localparam logic signed [WIDE_W-1:0] OFFSET_LIMIT = 64'sd2 <<< FRAC_BITS;
    localparam logic signed [MUL_W-1:0]  NOISE_GAIN   = 33'sd70;
    localparam logic signed [MUL_W-1:0]  NOISE_BIAS   = 33'sd16777216;

    localparam logic signed [ACC_W:0] SAT_MAX = (ACC_W+1)'(64'sd2147483647);
    localparam logic signed [ACC_W:0] SAT_MIN = (ACC_W+1)'(-64'sd2147483648);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUT_MIN   = 2'd0,
        CFG_OUT_MAX   = 2'd1,
        CFG_INV_SCALE = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } op_t;

    typedef enum logic [5:0] {
        S_IDLE, S_MULX, S_MULY, S_MULW,
        S_OCT, S_SHI, S_SLO, S_SSUM, S_CELL, S_THI, S_TLO, S_TSUM, S_OFS,
        S_L0, S_L1, S_L2, S_L3, S_L4, S_L5, S_L6,
        S_CSET, S_CDX, S_CDY, S_CR, S_CR2, S_CR4, S_CDOT, S_CACC,
        S_NZ, S_MAP, S_MAPD, S_DIV, S_DWAIT, S_OUT
    } state_t;

    // v mod 12 for a byte: v/12 by reciprocal, exact over 0..255
    function automatic logic [3:0] grad_mod12(input logic [VAL_W-1:0] v);
        logic [15:0] prod;
        logic [4:0]  q;
        logic [VAL_W-1:0] rem;
        prod = 16'(v) * 16'd171;
        q    = prod[15:11];
        rem  = v - VAL_W'(q) * VAL_W'(12);
        return rem[3:0];
    endfunction

    // gradient dot product; codes 0..11 only
    function automatic logic signed [DOT_W-1:0] grad_dot(
        input logic [3:0]            g,
        input logic signed [Q_W-1:0] dx,
        input logic signed [Q_W-1:0] dy
    );
        logic signed [DOT_W-1:0] ex;
        logic signed [DOT_W-1:0] ey;
        logic signed [DOT_W-1:0] tx;
        logic signed [DOT_W-1:0] ty;
        ex = DOT_W'(dx);
        ey = DOT_W'(dy);
        if (!g[3])
            tx = g[0] ? -ex : ex;
        else
            tx = '0;
        if (g[3])
            ty = g[0] ? -ey : ey;
        else if (!g[2])
            ty = g[1] ? -ey : ey;
        else
            ty = '0;
        return tx + ty;
    endfunction

    // cell offset: clamp to +-2 cells, move to Q24
    function automatic logic signed [Q_W-1:0] to_q24(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] c;
        if (v > OFFSET_LIMIT)
            c = OFFSET_LIMIT;
        else if (v < -OFFSET_LIMIT)
            c = -OFFSET_LIMIT;
        else
            c = v;
        return Q_W'(c <<< (24 - FRAC_BITS));
    endfunction

endpackage

FILE: src/octave_simplex_noise_2d.sv
// ----------------------------------------------------------------------------
// octave_simplex_noise_2d
// Fixed-point 2D simplex noise summed over up to eight octaves, built on one
// shared 33x33 multiplier, a 256-byte permutation RAM and a serial divider.
// ----------------------------------------------------------------------------
//  channel   signals                                          dir
//  command   start, busy (out), operation, x_coord, y_coord,  in
//            octave_count, table_index, table_value
//  result    done, noise_value                                out
//  config    cfg_write, cfg_index, cfg_data                   in
//
//  A table write leaves busy low.
//  An evaluate with zero octaves returns zero.
//  An octave skips the remaining multiplies of a corner that falls off.
//  Each octave runs up to 21 multiplies and 6 dependent table reads through the
//  shared multiplier and the single RAM read port; the final weighting
//  divide is one quotient bit per cycle.
//  Reset clears control and resets the configuration registers; the table is undefined until written.
//  done is a one-cycle transfer; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module octave_simplex_noise_2d (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  operation,
    input  logic signed [osn_pkg::DATA_W-1:0]     x_coord,
    input  logic signed [osn_pkg::DATA_W-1:0]     y_coord,
    input  logic [osn_pkg::OCT_W-1:0]             octave_count,
    input  logic [osn_pkg::TABLE_AW-1:0]          table_index,
    input  logic [osn_pkg::VAL_W-1:0]             table_value,
    output logic                                  done,
    output logic signed [osn_pkg::DATA_W-1:0]     noise_value,
    input  logic                                  cfg_write,
    input  logic [osn_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [osn_pkg::DATA_W-1:0]            cfg_data
);
    import osn_pkg::*;

    state_t state_reg, state_next;

    logic signed [DATA_W-1:0] out_min_reg, out_max_reg;
    logic [DATA_W-1:0]        inv_scale_reg;

    logic signed [WIDE_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [WIDE_W-1:0] xs_reg, xs_next, ys_reg, ys_next;
    logic signed [WIDE_W-1:0] tmp_reg, tmp_next, s_reg, s_next;
    logic [OCT_W-1:0]         oct_reg, oct_next, k_reg, k_next;
    logic [TABLE_AW-1:0]      ci_reg, ci_next, cj_reg, cj_next;
    logic signed [Q_W-1:0]    x0_reg, x0_next, y0_reg, y0_next;
    logic signed [Q_W-1:0]    dx_reg, dx_next, dy_reg, dy_next;
    logic                     i1_reg, i1_next;
    logic [3:0]               g0_reg, g0_next, g1_reg, g1_next, g2_reg, g2_next;
    logic [1:0]               c_reg, c_next;
    logic signed [R_W-1:0]    r_reg, r_next;
    logic signed [NSUM_W-1:0] nsum_reg, nsum_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [DATA_W-1:0] res_reg, res_next;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic [TABLE_AW-1:0]      ram_raddr;
    logic [VAL_W-1:0]         ram_rdata;
    logic                     tbl_we;
    logic                     div_start, div_done;
    logic [ACC_W-1:0]         div_dividend, div_quot;
    logic [DEN_W-1:0]         den;

    logic                     accept;
    logic [OCT_W-1:0]         oct_sat;
    logic [SH_W-1:0]          sh;
    logic signed [WIDE_W-1:0] ex, ey, mex, mey;
    logic [3:0]               gcur;
    logic signed [DOT_W-1:0]  dot;
    logic signed [M_W-1:0]    mval;
    logic signed [ACC_W:0]    qs;
    logic [R_W-1:0]           sq_term;

    assign accept  = start && !busy;
    assign tbl_we  = accept && (operation == OP_WRITE);
    assign oct_sat = (octave_count > OCT_W'(MAX_OCTAVES)) ? OCT_W'(MAX_OCTAVES) : octave_count;
    assign sh      = SH_W'(SCALE_FRAC) - SH_W'(k_reg) + SH_W'(1);
    assign ex      = xs_reg + s_reg;
    assign ey      = ys_reg + s_reg;
    assign mex     = {ex[WIDE_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}};
    assign mey     = {ey[WIDE_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}};
    assign gcur    = (c_reg == 2'd0) ? g0_reg : ((c_reg == 2'd1) ? g1_reg : g2_reg);
    assign dot     = grad_dot(gcur, dx_reg, dy_reg);
    assign sq_term = {1'b0, prod[53:24]};
    assign mval    = M_W'(out_min_reg) + M_W'($signed(prod[64:25]));
    assign den     = DEN_W'((9'd1 << oct_reg) - 9'd1);
    assign div_dividend = acc_reg[ACC_W-1]
                        ? ACC_W'(-acc_reg + ACC_W'(den) - ACC_W'(1))
                        : ACC_W'(acc_reg);
    assign qs = acc_reg[ACC_W-1] ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});

    osn_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_SIZE)) u_perm (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (table_index),
        .wdata (table_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    osn_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    osn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (den),
        .done     (div_done),
        .quotient (div_quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && operation == OP_EVAL)
                    state_next = (oct_sat == '0) ? S_OUT : S_MULX;
            end
            S_MULX:  state_next = S_MULY;
            S_MULY:  state_next = S_MULW;
            S_MULW:  state_next = S_OCT;
            S_OCT:   state_next = S_SHI;
            S_SHI:   state_next = S_SLO;
            S_SLO:   state_next = S_SSUM;
            S_SSUM:  state_next = S_CELL;
            S_CELL:  state_next = S_THI;
            S_THI:   state_next = S_TLO;
            S_TLO:   state_next = S_TSUM;
            S_TSUM:  state_next = S_OFS;
            S_OFS:   state_next = S_L0;
            S_L0:    state_next = S_L1;
            S_L1:    state_next = S_L2;
            S_L2:    state_next = S_L3;
            S_L3:    state_next = S_L4;
            S_L4:    state_next = S_L5;
            S_L5:    state_next = S_L6;
            S_L6:    state_next = S_CSET;
            S_CSET:  state_next = S_CDX;
            S_CDX:   state_next = S_CDY;
            S_CDY:   state_next = S_CR;
            S_CR:    state_next = S_CR2;
            S_CR2:
            begin
                if (!r_reg[R_W-1])
                    state_next = S_CR4;
                else
                    state_next = (c_reg == 2'd2) ? S_NZ : S_CSET;
            end
            S_CR4:   state_next = S_CDOT;
            S_CDOT:  state_next = S_CACC;
            S_CACC:  state_next = (c_reg == 2'd2) ? S_NZ : S_CSET;
            S_NZ:    state_next = S_MAP;
            S_MAP:   state_next = S_MAPD;
            S_MAPD:  state_next = (k_reg == oct_reg) ? S_DIV : S_OCT;
            S_DIV:   state_next = S_DWAIT;
            S_DWAIT: state_next = div_done ? S_OUT : S_DWAIT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // multiplier operands, table read address, divider kick
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        ram_raddr = cj_reg;
        div_start = 1'b0;
        unique case (state_reg)
            S_MULX:
            begin
                mul_a = MUL_W'(x_reg);
                mul_b = $signed({1'b0, inv_scale_reg});
            end
            S_MULY:
            begin
                mul_a = MUL_W'(y_reg);
                mul_b = $signed({1'b0, inv_scale_reg});
            end
            S_SHI:
            begin
                mul_a = MUL_W'($signed(tmp_reg[WIDE_W-1:32]));
                mul_b = $signed({1'b0, F2_Q32});
            end
            S_SLO:
            begin
                mul_a = $signed({1'b0, tmp_reg[31:0]});
                mul_b = $signed({1'b0, F2_Q32});
            end
            S_THI:
            begin
                mul_a = MUL_W'($signed(tmp_reg[WIDE_W-1:32]));
                mul_b = $signed({1'b0, G2_Q32});
            end
            S_TLO:
            begin
                mul_a = $signed({1'b0, tmp_reg[31:0]});
                mul_b = $signed({1'b0, G2_Q32});
            end
            S_L0: ram_raddr = cj_reg;
            S_L1: ram_raddr = ci_reg + ram_rdata;
            S_L2: ram_raddr = cj_reg + (i1_reg ? TABLE_AW'(0) : TABLE_AW'(1));
            S_L3: ram_raddr = ci_reg + TABLE_AW'(i1_reg) + ram_rdata;
            S_L4: ram_raddr = cj_reg + TABLE_AW'(1);
            S_L5: ram_raddr = ci_reg + TABLE_AW'(1) + ram_rdata;
            S_CDX:
            begin
                mul_a = MUL_W'(dx_reg);
                mul_b = MUL_W'(dx_reg);
            end
            S_CDY:
            begin
                mul_a = MUL_W'(dy_reg);
                mul_b = MUL_W'(dy_reg);
            end
            S_CR2:
            begin
                mul_a = MUL_W'(r_reg);
                mul_b = MUL_W'(r_reg);
            end
            S_CR4:
            begin
                mul_a = $signed({10'b0, prod[46:24]});
                mul_b = $signed({10'b0, prod[46:24]});
            end
            S_CDOT:
            begin
                mul_a = $signed({12'b0, prod[44:24]});
                mul_b = MUL_W'(dot);
            end
            S_NZ:
            begin
                mul_a = MUL_W'(nsum_reg);
                mul_b = NOISE_GAIN;
            end
            S_MAP:
            begin
                mul_a = prod[MUL_W-1:0] + NOISE_BIAS;
                mul_b = MUL_W'(out_max_reg) - MUL_W'(out_min_reg);
            end
            S_DIV: div_start = 1'b1;
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        xs_next   = xs_reg;
        ys_next   = ys_reg;
        tmp_next  = tmp_reg;
        s_next    = s_reg;
        oct_next  = oct_reg;
        k_next    = k_reg;
        ci_next   = ci_reg;
        cj_next   = cj_reg;
        x0_next   = x0_reg;
        y0_next   = y0_reg;
        dx_next   = dx_reg;
        dy_next   = dy_reg;
        i1_next   = i1_reg;
        g0_next   = g0_reg;
        g1_next   = g1_reg;
        g2_next   = g2_reg;
        c_next    = c_reg;
        r_next    = r_reg;
        nsum_next = nsum_reg;
        acc_next  = acc_reg;
        res_next  = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                x_next   = WIDE_W'(x_coord);
                y_next   = WIDE_W'(y_coord);
                oct_next = oct_sat;
                k_next   = OCT_W'(1);
                acc_next = '0;
                res_next = '0;
            end
            S_MULY: x_next = prod[WIDE_W-1:0];
            S_MULW: y_next = prod[WIDE_W-1:0];
            S_OCT:
            begin
                xs_next  = x_reg >>> sh;
                ys_next  = y_reg >>> sh;
                tmp_next = (x_reg >>> sh) + (y_reg >>> sh);
            end
            S_SLO:  s_next = prod[WIDE_W-1:0];
            S_SSUM: s_next = s_reg + $signed({32'b0, prod[63:32]});
            S_CELL:
            begin
                ci_next  = ex[FRAC_BITS+TABLE_AW-1:FRAC_BITS];
                cj_next  = ey[FRAC_BITS+TABLE_AW-1:FRAC_BITS];
                xs_next  = xs_reg - mex;
                ys_next  = ys_reg - mey;
                tmp_next = mex + mey;
            end
            S_TLO:  s_next = prod[WIDE_W-1:0];
            S_TSUM: s_next = s_reg + $signed({32'b0, prod[63:32]});
            S_OFS:
            begin
                x0_next = to_q24(xs_reg + s_reg);
                y0_next = to_q24(ys_reg + s_reg);
            end
            S_L0: i1_next = (x0_reg > y0_reg);
            S_L2: g0_next = grad_mod12(ram_rdata);
            S_L4: g1_next = grad_mod12(ram_rdata);
            S_L6:
            begin
                g2_next   = grad_mod12(ram_rdata);
                c_next    = 2'd0;
                nsum_next = '0;
            end
            S_CSET:
            begin
                // corner 0 at the cell origin, corner 1 along the longer axis
                if (c_reg == 2'd0)
                begin
                    dx_next = x0_reg;
                    dy_next = y0_reg;
                end
                else if (c_reg == 2'd1)
                begin
                    dx_next = x0_reg - (i1_reg ? ONE24 : '0) + G2_Q24;
                    dy_next = y0_reg - (i1_reg ? '0 : ONE24) + G2_Q24;
                end
                else
                begin
                    dx_next = x0_reg - ONE24 + G2_Q24 + G2_Q24;
                    dy_next = y0_reg - ONE24 + G2_Q24 + G2_Q24;
                end
            end
            S_CDY: r_next = HALF24 - $signed(sq_term);
            S_CR:  r_next = r_reg - $signed(sq_term);
            S_CR2:
            begin
                if (r_reg[R_W-1])
                    c_next = c_reg + 2'd1;
            end
            S_CACC:
            begin
                nsum_next = nsum_reg + $signed(prod[24+NSUM_W-1:24]);
                c_next    = c_reg + 2'd1;
            end
            S_MAPD:
            begin
                acc_next = (acc_reg <<< 1) + ACC_W'(mval);
                k_next   = k_reg + OCT_W'(1);
            end
            S_DWAIT:
            begin
                if (qs > SAT_MAX)
                    res_next = DATA_W'(SAT_MAX);
                else if (qs < SAT_MIN)
                    res_next = DATA_W'(SAT_MIN);
                else
                    res_next = DATA_W'(qs);
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_min_reg   <= '0;
            out_max_reg   <= 32'sd65536;
            inv_scale_reg <= 32'd65536;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                if (cfg_index == CFG_OUT_MIN)
                    out_min_reg <= $signed(cfg_data);
                if (cfg_index == CFG_OUT_MAX)
                    out_max_reg <= $signed(cfg_data);
                if (cfg_index == CFG_INV_SCALE)
                    inv_scale_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        xs_reg   <= xs_next;
        ys_reg   <= ys_next;
        tmp_reg  <= tmp_next;
        s_reg    <= s_next;
        oct_reg  <= oct_next;
        k_reg    <= k_next;
        ci_reg   <= ci_next;
        cj_reg   <= cj_next;
        x0_reg   <= x0_next;
        y0_reg   <= y0_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        i1_reg   <= i1_next;
        g0_reg   <= g0_next;
        g1_reg   <= g1_next;
        g2_reg   <= g2_next;
        c_reg    <= c_next;
        r_reg    <= r_next;
        nsum_reg <= nsum_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = (state_reg == S_OUT);
    assign noise_value = res_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_zero_octaves: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_EVAL && octave_count == '0) |=> (done && noise_value == '0))
        else $error("zero-octave evaluate did not return zero next cycle");

    a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_WRITE) |=> !busy)
        else $error("table write left the block busy");

    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DWAIT))
        else $error("divider finished outside the wait state");

endmodule

FILE: src/osn_ram.sv
// ----------------------------------------------------------------------------
// osn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module osn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/osn_mul.sv
// ----------------------------------------------------------------------------
// osn_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module osn_mul (
    input  logic                                clk,
    input  logic signed [osn_pkg::MUL_W-1:0]    a,
    input  logic signed [osn_pkg::MUL_W-1:0]    b,
    output logic signed [osn_pkg::PROD_W-1:0]   p
);
    import osn_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign p = prod_reg;

endmodule

FILE: src/osn_div.sv
// ----------------------------------------------------------------------------
// osn_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module osn_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [osn_pkg::ACC_W-1:0]    dividend,
    input  logic [osn_pkg::DEN_W-1:0]    divisor,
    output logic                         done,
    output logic [osn_pkg::ACC_W-1:0]    quotient
);
    import osn_pkg::*;

    localparam int CNT_W = $clog2(ACC_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [ACC_W-1:0] dq_reg, dq_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;

    always_comb
    begin
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dq_reg[ACC_W-1]};
        if (start)
        begin
            cnt_next = CNT_W'(ACC_W);
            dq_next  = dividend;
            rem_next = '0;
            den_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
                dq_next  = {dq_reg[ACC_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = DEN_W'(trial);
                dq_next  = {dq_reg[ACC_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

FILE: verif/octave_simplex_noise_2d_tb.sv
// ----------------------------------------------------------------------------
// octave_simplex_noise_2d_tb
// Loads the permutation table, runs a directed table of evaluate and table
// write commands, then random traffic under several output ranges and
// scales. Each noise result is checked against a fixed-point predictor or a fixed expected value.
// ----------------------------------------------------------------------------
module octave_simplex_noise_2d_tb;
    import osn_pkg::*;

    localparam int  ITEMS_PER_PHASE = 140;
    localparam int  QUIET_LIMIT     = 6000;
    localparam longint ONE_Q24      = 64'sd1 << 24;
    localparam longint HALF_Q24     = 64'sd1 << 23;
    localparam longint G2_IN_Q24    = (64'sd907633386 + 128) >>> 8;
    localparam longint CELL_CLAMP   = 64'sd2 << 16;
    localparam logic [63:0] SKEW_Q32   = 64'd1572067139;
    localparam logic [63:0] UNSKEW_Q32 = 64'd907633386;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               operation = 1'b0;
    logic signed [31:0] x_coord = '0;
    logic signed [31:0] y_coord = '0;
    logic [3:0]         octave_count = '0;
    logic [7:0]         table_index = '0;
    logic [7:0]         table_value = '0;
    logic               cfg_write = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    wire                busy;
    wire                done;
    wire signed [31:0]  noise_value;

    octave_simplex_noise_2d dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .x_coord(x_coord), .y_coord(y_coord),
        .octave_count(octave_count), .table_index(table_index),
        .table_value(table_value), .done(done), .noise_value(noise_value),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor state
    longint      map_low = 0;
    longint      map_high = 65536;
    logic [31:0] coord_scale = 32'd65536;
    logic [7:0]  perm [256];

    logic [31:0] expected_noise [$];
    int          error_count = 0;
    int          eval_count = 0;
    int          write_count = 0;
    int          result_count = 0;
    int          quiet_cycles = 0;
    bit          calm = 1'b0;

    function automatic logic [63:0] mul_frac32(input logic [63:0] a, input logic [63:0] c);
        logic [63:0] hi;
        logic [63:0] lo;
        hi = $signed(a) >>> 32;
        lo = {32'b0, a[31:0]};
        return hi * c + ((lo * c) >> 32);
    endfunction

    function automatic longint corner_falloff(input longint dx, input longint dy,
                                              input logic [7:0] g);
        int gx [12] = '{1, -1, 1, -1, 1, -1, 1, -1, 0, 0, 0, 0};
        int gy [12] = '{1, 1, -1, -1, 0, 0, 0, 0, 1, -1, 1, -1};
        longint r;
        longint r2;
        longint r4;
        longint dot;
        r = HALF_Q24 - ((dx * dx) >>> 24) - ((dy * dy) >>> 24);
        if (r < 0)
            return 0;
        r2  = (r * r) >>> 24;
        r4  = (r2 * r2) >>> 24;
        dot = longint'(gx[g]) * dx + longint'(gy[g]) * dy;
        return (r4 * dot) >>> 24;
    endfunction

    function automatic longint offset_q24(input logic [63:0] f);
        longint v;
        v = $signed(f);
        if (v > CELL_CLAMP)
            v = CELL_CLAMP;
        if (v < -CELL_CLAMP)
            v = -CELL_CLAMP;
        return v * 256;
    endfunction

    function automatic longint simplex_mapped(input logic [63:0] xs, input logic [63:0] ys);
        logic [63:0] s;
        logic [63:0] ci;
        logic [63:0] cj;
        logic [63:0] t;
        longint      x0, y0, x1, y1, x2, y2, nz, span;
        logic [7:0]  i1, j1, g0, g1, g2;
        s  = mul_frac32(xs + ys, SKEW_Q32);
        ci = $signed(xs + s) >>> 16;
        cj = $signed(ys + s) >>> 16;
        t  = mul_frac32((ci + cj) << 16, UNSKEW_Q32);
        x0 = offset_q24(xs - (ci << 16) + t);
        y0 = offset_q24(ys - (cj << 16) + t);
        i1 = (x0 > y0) ? 8'd1 : 8'd0;
        j1 = 8'd1 - i1;
        x1 = x0 - longint'(i1) * ONE_Q24 + G2_IN_Q24;
        y1 = y0 - longint'(j1) * ONE_Q24 + G2_IN_Q24;
        x2 = x0 - ONE_Q24 + 2 * G2_IN_Q24;
        y2 = y0 - ONE_Q24 + 2 * G2_IN_Q24;
        // lattice indices wrap at 256, so only the low byte matters
        g0 = perm[8'(ci[7:0] + perm[cj[7:0]])] % 8'd12;
        g1 = perm[8'(ci[7:0] + i1 + perm[8'(cj[7:0] + j1)])] % 8'd12;
        g2 = perm[8'(ci[7:0] + 8'd1 + perm[8'(cj[7:0] + 8'd1)])] % 8'd12;
        nz = 70 * (corner_falloff(x0, y0, g0) + corner_falloff(x1, y1, g1)
                   + corner_falloff(x2, y2, g2));
        span = map_high - map_low;
        return map_low + ((span * (nz + ONE_Q24)) >>> 25);
    endfunction

    function automatic logic [31:0] octave_noise_sum(input logic signed [31:0] xc,
                                                     input logic signed [31:0] yc,
                                                     input logic [3:0] oc);
        longint      xw, yw, acc, den, q;
        int          n;
        logic [63:0] xs, ys;
        n = (oc > MAX_OCTAVES) ? MAX_OCTAVES : oc;
        if (n == 0)
            return '0;
        xw  = longint'(xc) * longint'({32'b0, coord_scale});
        yw  = longint'(yc) * longint'({32'b0, coord_scale});
        acc = 0;
        for (int k = 1; k <= n; k++)
        begin
            xs  = xw >>> (SCALE_FRAC - (k - 1));
            ys  = yw >>> (SCALE_FRAC - (k - 1));
            acc += simplex_mapped(xs, ys) * (64'sd1 << (n - k));
        end
        den = (64'sd1 << n) - 1;
        q   = acc / den;
        if (acc % den != 0 && acc < 0)
            q--;
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        return q[31:0];
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("ERROR t=%0t %s: got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // one command transfer; predicts on acceptance
    task automatic issue(input op_t op, input logic signed [31:0] xv, input logic signed [31:0] yv,
                         input logic [3:0] oc, input logic [7:0] ix, input logic [7:0] vl,
                         input bit fixed, input logic [31:0] fixed_val);
        if (!calm && $urandom_range(0, 99) < 10)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start        <= 1'b1;
        operation    <= op;
        x_coord      <= xv;
        y_coord      <= yv;
        octave_count <= oc;
        table_index  <= ix;
        table_value  <= vl;
        do
            @(posedge clk);
        while (busy);
        if (op == OP_WRITE)
        begin
            perm[ix] = vl;
            write_count++;
        end
        else
        begin
            expected_noise.push_back(fixed ? fixed_val : octave_noise_sum(xv, yv, oc));
            eval_count++;
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_noise.size() != 0)
            @(posedge clk);
        // a trailing table write may still be settling
        repeat (20) @(posedge clk);
    endtask

    task automatic set_ranges(input logic [31:0] lo, input logic [31:0] hi, input logic [31:0] sc);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= CFG_OUT_MIN;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= CFG_OUT_MAX;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= CFG_INV_SCALE;
        cfg_data  <= sc;
        @(posedge clk);
        cfg_write <= 1'b0;
        map_low     = longint'($signed(lo));
        map_high    = longint'($signed(hi));
        coord_scale = sc;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0, 1: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
            2:    return $urandom;
            default: return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 255)
                                                 : 32'h8000_0000 + $urandom_range(0, 255);
        endcase
    endfunction

    task automatic random_phase();
        logic [3:0] oc;
        for (int n = 0; n < ITEMS_PER_PHASE; n++)
        begin
            calm = (n >= 40 && n < 100);
            if ($urandom_range(0, 99) < 20)
                issue(OP_WRITE, $urandom, $urandom, 4'($urandom), 8'($urandom), 8'($urandom),
                      1'b0, '0);
            else
            begin
                oc = ($urandom_range(0, 99) < 3) ? 4'($urandom_range(9, 15))
                                                 : 4'($urandom_range(0, 8));
                issue(OP_EVAL, rand_coord(), rand_coord(), oc, 8'($urandom), 8'($urandom),
                      1'b0, '0);
            end
        end
        calm = 1'b0;
    endtask

    // result checker; done cannot be stalled
    always @(posedge clk)
    begin
        if (done)
        begin
            result_count++;
            if (expected_noise.size() == 0)
                report("unexpected result", noise_value, 'x);
            else if (noise_value !== expected_noise[0])
                report("noise_value", noise_value, expected_noise.pop_front());
            else
                void'(expected_noise.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > QUIET_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
                $display("FAIL octave_simplex_noise_2d");
                $finish;
            end
        end
    end

    typedef struct {
        op_t              op;
        logic signed [31:0] xv;
        logic signed [31:0] yv;
        logic [3:0]       oc;
        logic [7:0]       ix;
        logic [7:0]       vl;
        bit               fixed;
        logic [31:0]      want;
    } cmd_row_t;

    cmd_row_t directed [16] = '{
        '{OP_EVAL,  32'sd0,        32'sd0,        4'd0,  8'd0,   8'd0,   1'b1, 32'd0},
        '{OP_EVAL,  32'h8000_0000, 32'h7fff_ffff, 4'd0,  8'd0,   8'd0,   1'b1, 32'd0},
        '{OP_EVAL,  32'sd0,        32'sd0,        4'd1,  8'd0,   8'd0,   1'b0, 32'd0},
        '{OP_EVAL,  32'sd65536,    32'sd0,        4'd1,  8'd0,   8'd0,   1'b0, 32'd0},
        '{OP_EVAL,  -32'sd65536,   -32'sd65536,   4'd2,  8'd0,   8'd0,   1'b0, 32'd0},
        '{OP_EVAL,  -32'sd1,       -32'sd1,       4'd3,  8'd0,   8'd0,   1'b0, 32'd0},
        '{OP_EVAL,  32'h7fff_ffff, 32'h7fff_ffff, 4'd8,  8'd0,   8'd0,   1'b0, 32'd0},
        '{OP_EVAL,  32'h8000_0000, 32'h8000_0000, 4'd8,  8'd0,   8'd0,   1'b0, 32'd0},
        '{OP_EVAL,  32'h7fff_ffff, 32'h8000_0000, 4'd8,  8'd0,   8'd0,   1'b0, 32'd0},
        '{OP_EVAL,  32'sd98304,    -32'sd40000,   4'd9,  8'd0,   8'd0,   1'b0, 32'd0},
        '{OP_EVAL,  32'sd12345,    32'sd54321,    4'd15, 8'd0,   8'd0,   1'b0, 32'd0},
        '{OP_WRITE, 32'sd0,        32'sd0,        4'd0,  8'd0,   8'd255, 1'b0, 32'd0},
        '{OP_WRITE, 32'sd0,        32'sd0,        4'd0,  8'd255, 8'd0,   1'b0, 32'd0},
        '{OP_WRITE, 32'sd0,        32'sd0,        4'd0,  8'd128, 8'd127, 1'b0, 32'd0},
        '{OP_EVAL,  32'sd0,        32'sd0,        4'd1,  8'd0,   8'd0,   1'b0, 32'd0},
        '{OP_EVAL,  -32'sd200000,  32'sd131072,   4'd4,  8'd0,   8'd0,   1'b0, 32'd0}
    };

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every entry must be written before any evaluate reads it
        for (int i = 0; i < 256; i++)
            issue(OP_WRITE, '0, '0, '0, 8'(i), 8'($urandom), 1'b0, '0);
        foreach (directed[i])
            issue(directed[i].op, directed[i].xv, directed[i].yv, directed[i].oc,
                  directed[i].ix, directed[i].vl, directed[i].fixed, directed[i].want);
        random_phase();

        set_ranges(32'h8000_0000, 32'h7fff_ffff, 32'd1);
        random_phase();
        set_ranges(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
        random_phase();
        set_ranges(32'h0001_2345, 32'h0001_2345, 32'd65536);
        issue(OP_EVAL, 32'sd77777, -32'sd5555, 4'd5, 8'd0, 8'd0, 1'b1, 32'h0001_2345);
        random_phase();
        set_ranges($urandom, $urandom, 32'd0);
        random_phase();
        set_ranges(32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000,
                   32'($urandom_range(0, 32'h0004_0000)), $urandom_range(1, 32'h0004_0000));
        random_phase();

        drain();
        repeat (50) @(posedge clk);
        $display("covered %0d evaluates and %0d table writes over six range/scale settings",
                 eval_count, write_count);
        $display("%0d results checked, %0d mismatches", result_count, error_count);
        if (error_count == 0 && expected_noise.size() == 0)
            $display("PASS octave_simplex_noise_2d");
        else
            $display("FAIL octave_simplex_noise_2d");
        $finish;
    end

endmodule
